// ===== design/stepper_full_step_sequencer_homing_macros.svh =====
// Assertion macros for the stepper sequencer.
// Used by the top level; expects clk and arst_n in scope.
`ifndef STEPPER_FULL_STEP_SEQUENCER_HOMING_MACROS_SVH
`define STEPPER_FULL_STEP_SEQUENCER_HOMING_MACROS_SVH

// concurrent check on the block clock, off while in reset
`define STPSEQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// same check, but also evaluated during reset
`define STPSEQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/stpseq_pkg.sv =====
// Shared types, codes and constants for the stepper sequencer.
// No dependencies.
`timescale 1ns / 1ps

package stpseq_pkg;

	localparam int POSITION_BITS_DEF = 32;
	localparam int IN_TDATA_W        = 24;
	localparam int OUT_TDATA_W       = 48;
	localparam int HOME_TARGET       = -50000;
	localparam int STEP_MOVE         = 4;

	localparam logic [15:0]        STEPS_PER_TURN_RST = 16'd200;
	localparam logic signed [15:0] ROTATION_MIN_RST   = -16'sd100;
	localparam logic signed [15:0] ROTATION_MAX_RST   = 16'sd100;

	typedef enum logic [1:0] {
		ACT_TICK       = 2'd0,
		ACT_SET_TARGET = 2'd1,
		ACT_HOME       = 2'd2,
		ACT_NONE       = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_STEPS_PER_TURN = 2'd0,
		REG_ROTATION_MIN   = 2'd1,
		REG_ROTATION_MAX   = 2'd2,
		REG_UNUSED         = 2'd3
	} reg_index_t;

	// homing status flags
	typedef struct packed {
		logic home_low;
		logic home_high;
		logic indexed;
		logic homing;
	} flags_t;

	// bridge bits: [3] high_a, [2] low_a, [1] high_b, [0] low_b
	localparam logic [3:0] PAT_LOW_DIR [4]  = '{4'd5, 4'd9, 4'd10, 4'd6};
	localparam logic [3:0] PAT_HIGH_DIR [4] = '{4'd10, 4'd9, 4'd5, 4'd6};

endpackage

// ===== design/stpseq_target.sv =====
// Clamps a rotation request to the configured limits and scales it to steps.
// Depends on stpseq_pkg.
`timescale 1ns / 1ps

module stpseq_target import stpseq_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic signed [15:0]        rotations,
	input  logic signed [15:0]        rotation_min,
	input  logic signed [15:0]        rotation_max,
	input  logic [15:0]               steps_per_turn,
	output logic [POSITION_BITS-1:0]  target
);

	logic signed [15:0] rot_lo;
	logic signed [15:0] rot_clamped;
	logic signed [16:0] rot_ext;
	logic signed [16:0] steps_ext;
	logic signed [32:0] product;

	always_comb begin
		// min first, then max: max wins if the limits cross
		rot_lo      = (rotations < rotation_min) ? rotation_min : rotations;
		rot_clamped = (rot_lo > rotation_max) ? rotation_max : rot_lo;
		rot_ext     = {rot_clamped[15], rot_clamped};
		steps_ext   = {1'b0, steps_per_turn};
		product     = rot_ext * steps_ext;
		target      = POSITION_BITS'(product);
	end

endmodule

// ===== design/stpseq_tick.sv =====
// Next state for one step tick: bridge phase walk, position move, index handling.
// Depends on stpseq_pkg.
`timescale 1ns / 1ps

module stpseq_tick import stpseq_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                      index_level,
	input  logic [1:0]                phase,
	input  logic [3:0]                bridge,
	input  logic [POSITION_BITS-1:0]  pos,
	input  logic [POSITION_BITS-1:0]  target,
	input  flags_t                    flags,
	output logic [1:0]                phase_nx,
	output logic [3:0]                bridge_nx,
	output logic [POSITION_BITS-1:0]  pos_nx,
	output logic [POSITION_BITS-1:0]  target_nx,
	output flags_t                    flags_nx,
	output logic                      stop
);

	localparam logic [POSITION_BITS-1:0] MOVE = POSITION_BITS'(STEP_MOVE);

	logic move_low;
	logic move_high;
	logic [1:0] phase_inc;

	always_comb begin
		move_low  = $signed(target) < $signed(pos);
		move_high = $signed(pos) < $signed(target);
		phase_inc = phase + 2'd1;

		phase_nx  = phase;
		bridge_nx = bridge;
		pos_nx    = pos;
		target_nx = target;
		flags_nx  = flags;
		stop      = 1'b0;

		if (move_low) begin
			if (!flags.home_low) begin
				bridge_nx = PAT_LOW_DIR[phase];
				phase_nx  = phase_inc;
				if (phase_inc == 2'd0) begin
					pos_nx = pos - MOVE;
				end
			end
			if (index_level && !flags.home_high) begin
				flags_nx.home_low = 1'b1;
				// auto-home finishes here: zero the axis
				if (flags.homing) begin
					target_nx        = '0;
					pos_nx           = '0;
					flags_nx.indexed = 1'b1;
					flags_nx.homing  = 1'b0;
				end
			end else begin
				flags_nx.home_low = 1'b0;
			end
		end else if (move_high) begin
			if (!flags.home_high) begin
				bridge_nx = PAT_HIGH_DIR[phase];
				phase_nx  = phase_inc;
				if (phase_inc == 2'd0) begin
					pos_nx = pos + MOVE;
				end
			end
			// hit the index at the high end: stop where we are
			if (index_level && !flags.home_low) begin
				flags_nx.home_high = 1'b1;
				stop               = 1'b1;
				target_nx          = pos_nx;
			end else begin
				flags_nx.home_high = 1'b0;
			end
		end
	end

endmodule

// ===== design/stepper_full_step_sequencer_homing.sv =====
// Top level of the two-phase full-step stepper sequencer with index homing.
// Depends on stpseq_pkg, stpseq_target, stpseq_tick and the macros header.
`timescale 1ns / 1ps

// Each input item (step tick, set-target or start-home command) gives exactly one
// result item with the bridge enables, position and homing flags after that item.
// An item is registered on entry, and its state update and result are computed
// into the output register when the output side can take them. An item can be
// accepted every cycle while the output is not stalled. The longest combinational
// path is the clamp and 17x17 multiply of the set-target command. Bridge enables
// hold between ticks. Configuration writes are taken on any cycle (cfg_ready is
// always high) and apply to later items.

`include "stepper_full_step_sequencer_homing_macros.svh"

module stepper_full_step_sequencer_homing import stpseq_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// config write channel
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [1:0]              cfg_index,
	input  logic [15:0]             cfg_data,
	// input items
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	// [0] index_level, [16:1] rotations, [23:17] zero
	input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
	// [1:0] action
	input  logic [1:0]              s_axis_tuser,
	// result items
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	// [0] high_a, [1] low_a, [2] high_b, [3] low_b, [35:4] position, [36] at_target,
	// [37] home_low_seen, [38] home_high_seen, [39] is_indexed, [40] homing_active,
	// [41] stop_sequence, [47:42] zero
	output logic [OUT_TDATA_W-1:0]  m_axis_tdata
);

	localparam logic [POSITION_BITS-1:0] HOME_POS = POSITION_BITS'(HOME_TARGET);

	// configuration
	logic [15:0]        steps_q;
	logic signed [15:0] rot_min_q;
	logic signed [15:0] rot_max_q;

	// input stage
	logic               valid_s1;
	action_t            action_s1;
	logic               index_s1;
	logic signed [15:0] rot_s1;

	// block state
	logic [1:0]               phase_q;
	logic [3:0]               bridge_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] target_q;
	flags_t                   flags_q;

	// output register
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic advance;
	logic proc;

	logic [POSITION_BITS-1:0] cmd_target;
	logic [1:0]               tk_phase;
	logic [3:0]               tk_bridge;
	logic [POSITION_BITS-1:0] tk_pos;
	logic [POSITION_BITS-1:0] tk_target;
	flags_t                   tk_flags;
	logic                     tk_stop;

	logic [1:0]               phase_nx;
	logic [3:0]               bridge_nx;
	logic [POSITION_BITS-1:0] pos_nx;
	logic [POSITION_BITS-1:0] target_nx;
	flags_t                   flags_nx;
	logic                     stop_nx;
	logic [OUT_TDATA_W-1:0]   result;

	assign cfg_ready     = 1'b1;
	assign advance       = !out_valid_q || m_axis_tready;
	assign proc          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	stpseq_target #(
		.POSITION_BITS (POSITION_BITS)
	) u_target (
		.rotations      (rot_s1),
		.rotation_min   (rot_min_q),
		.rotation_max   (rot_max_q),
		.steps_per_turn (steps_q),
		.target         (cmd_target)
	);

	stpseq_tick #(
		.POSITION_BITS (POSITION_BITS)
	) u_tick (
		.index_level (index_s1),
		.phase       (phase_q),
		.bridge      (bridge_q),
		.pos         (pos_q),
		.target      (target_q),
		.flags       (flags_q),
		.phase_nx    (tk_phase),
		.bridge_nx   (tk_bridge),
		.pos_nx      (tk_pos),
		.target_nx   (tk_target),
		.flags_nx    (tk_flags),
		.stop        (tk_stop)
	);

	always_comb begin
		phase_nx  = phase_q;
		bridge_nx = bridge_q;
		pos_nx    = pos_q;
		target_nx = target_q;
		flags_nx  = flags_q;
		stop_nx   = 1'b0;
		unique case (action_s1)
			ACT_TICK: begin
				phase_nx  = tk_phase;
				bridge_nx = tk_bridge;
				pos_nx    = tk_pos;
				target_nx = tk_target;
				flags_nx  = tk_flags;
				stop_nx   = tk_stop;
			end
			ACT_SET_TARGET: begin
				target_nx = cmd_target;
			end
			ACT_HOME: begin
				flags_nx.homing = 1'b1;
				if (!flags_q.home_low) begin
					target_nx = HOME_POS;
				end
			end
			default: begin
			end
		endcase

		result = {6'd0, stop_nx, flags_nx.homing, flags_nx.indexed, flags_nx.home_high,
			flags_nx.home_low, (pos_nx == target_nx), 32'(pos_nx),
			bridge_nx[0], bridge_nx[1], bridge_nx[2], bridge_nx[3]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q   <= STEPS_PER_TURN_RST;
			rot_min_q <= ROTATION_MIN_RST;
			rot_max_q <= ROTATION_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_index_t'(cfg_index))
				REG_STEPS_PER_TURN: steps_q   <= cfg_data;
				REG_ROTATION_MIN:   rot_min_q <= $signed(cfg_data);
				REG_ROTATION_MAX:   rot_max_q <= $signed(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// input stage: hold the item until the output side can take its result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			action_s1 <= action_t'(s_axis_tuser);
			index_s1  <= s_axis_tdata[0];
			rot_s1    <= $signed(s_axis_tdata[16:1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			bridge_q    <= '0;
			pos_q       <= '0;
			target_q    <= '0;
			flags_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (proc) begin
				phase_q  <= phase_nx;
				bridge_q <= bridge_nx;
				pos_q    <= pos_nx;
				target_q <= target_nx;
				flags_q  <= flags_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			out_data_q <= result;
		end
	end

	`STPSEQ_ASSERT(a_stop_at_target, m_axis_tvalid && m_axis_tdata[41] |-> m_axis_tdata[36] && m_axis_tdata[38], "stop pulse without stopping at target")
	`STPSEQ_ASSERT_ALWAYS(a_no_shoot_through, !(bridge_q[3] === 1'b1 && bridge_q[2] === 1'b1) && !(bridge_q[1] === 1'b1 && bridge_q[0] === 1'b1), "both switches of one bridge leg enabled")
	`STPSEQ_ASSERT(a_phase_on_tick, !(proc && action_s1 == ACT_TICK) |=> $stable(phase_q), "phase moved without a step tick")
	`STPSEQ_ASSERT(a_hold_stalled, valid_s1 && !advance |=> valid_s1 && $stable(rot_s1), "stalled item lost in input stage")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for stepper_full_step_sequencer_homing.
// Holds its own step/homing predictor and random bursty stimulus; depends on
// stpseq_pkg and the sequencer RTL.
`timescale 1ns / 1ps

module testbench;
	import stpseq_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOME_POS    = -50000;
	localparam int MAX_REPORTS = 30;

	// bit 3 high_a, bit 2 low_a, bit 1 high_b, bit 0 low_b
	localparam logic [3:0] WALK_DOWN [4] = '{4'd5, 4'd9, 4'd10, 4'd6};
	localparam logic [3:0] WALK_UP [4]   = '{4'd10, 4'd9, 4'd5, 4'd6};

	typedef struct {
		action_t     act;
		logic        idx;
		logic [15:0] rot;
	} motor_cmd_t;

	// laid out to match m_axis_tdata, lowest bit last
	typedef struct packed {
		logic [5:0]  pad;
		logic        stop;
		logic        homing;
		logic        indexed;
		logic        home_high;
		logic        home_low;
		logic        at_target;
		logic [31:0] position;
		logic        low_b;
		logic        high_b;
		logic        low_a;
		logic        high_a;
	} motor_status_t;

	typedef enum {RDY_ALWAYS, RDY_PATTERN, RDY_COIN, RDY_SPARSE} stall_mode_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	reg_index_t        cfg_index = REG_STEPS_PER_TURN;
	logic [15:0]       cfg_data = 16'd0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [23:0]       s_axis_tdata = 24'd0;
	logic [1:0]        s_axis_tuser = 2'd0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [47:0]       m_axis_tdata;

	// predictor copy of the registers and state
	logic [15:0]        spt_reg = 16'd200;
	logic signed [15:0] rot_min_reg = -16'sd100;
	logic signed [15:0] rot_max_reg = 16'sd100;
	logic [1:0]         mot_phase = 2'd0;
	logic signed [31:0] mot_pos = 32'sd0;
	logic signed [31:0] mot_target = 32'sd0;
	logic               seen_low = 1'b0;
	logic               seen_high = 1'b0;
	logic               indexed = 1'b0;
	logic               homing = 1'b0;
	logic [3:0]         bridge = 4'd0;

	motor_cmd_t    pending_cmds[$];
	motor_status_t expected_status[$];
	motor_cmd_t    next_cmd;
	int            n_queued = 0;
	int            n_moving = 0;
	int            n_checked = 0;
	int            fail_count = 0;
	int            cycle_count = 0;
	logic          item_taken = 1'b0;
	int            burst_left = 0;
	int            gap_left = 0;
	stall_mode_t   ready_mode = RDY_ALWAYS;
	logic [31:0]   ready_bits = 32'hFFFF_FFFF;
	int            ready_hold = 0;

	stepper_full_step_sequencer_homing dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #1 clk = ~clk;

	// advance the motor state by one command and return the status it reports
	function automatic motor_status_t apply_command(motor_cmd_t c);
		motor_status_t st;
		int rot;
		int lo;
		int hi;
		logic stop;
		st = '0;
		stop = 1'b0;
		case (c.act)
			ACT_TICK: begin
				if (mot_target < mot_pos) begin
					if (!seen_low) begin
						bridge = WALK_DOWN[mot_phase];
						mot_phase = mot_phase + 2'd1;
						if (mot_phase == 2'd0)
							mot_pos = mot_pos - 32'sd4;
					end
					if (c.idx && !seen_high) begin
						seen_low = 1'b1;
						if (homing) begin
							mot_target = 32'sd0;
							mot_pos = 32'sd0;
							indexed = 1'b1;
							homing = 1'b0;
						end
					end else begin
						seen_low = 1'b0;
					end
				end else if (mot_pos < mot_target) begin
					if (!seen_high) begin
						bridge = WALK_UP[mot_phase];
						mot_phase = mot_phase + 2'd1;
						if (mot_phase == 2'd0)
							mot_pos = mot_pos + 32'sd4;
					end
					// index on the way up: stop where we are
					if (c.idx && !seen_low) begin
						seen_high = 1'b1;
						stop = 1'b1;
						mot_target = mot_pos;
					end else begin
						seen_high = 1'b0;
					end
				end
			end
			ACT_SET_TARGET: begin
				rot = int'($signed(c.rot));
				lo = int'(rot_min_reg);
				hi = int'(rot_max_reg);
				if (rot < lo)
					rot = lo;
				if (rot > hi)
					rot = hi;
				mot_target = rot * int'({16'd0, spt_reg});
			end
			ACT_HOME: begin
				homing = 1'b1;
				if (!seen_low)
					mot_target = HOME_POS;
			end
			default: begin
			end
		endcase
		st.high_a = bridge[3];
		st.low_a = bridge[2];
		st.high_b = bridge[1];
		st.low_b = bridge[0];
		st.position = mot_pos;
		st.at_target = (mot_pos == mot_target);
		st.home_low = seen_low;
		st.home_high = seen_high;
		st.indexed = indexed;
		st.homing = homing;
		st.stop = stop;
		return st;
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	// monitor: registers, input items and result items, all at the rising edge
	always @(posedge clk) begin
		motor_status_t want;
		motor_status_t got;
		motor_cmd_t c;
		item_taken <= s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_STEPS_PER_TURN: spt_reg = cfg_data;
					REG_ROTATION_MIN: rot_min_reg = cfg_data;
					REG_ROTATION_MAX: rot_max_reg = cfg_data;
					default: begin
					end
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = motor_status_t'(m_axis_tdata);
				if (expected_status.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t ns: result expected none actual %h", $time, m_axis_tdata);
				end else begin
					want = expected_status.pop_front();
					n_checked++;
					compare_field("high_a", 32'(want.high_a), 32'(got.high_a));
					compare_field("low_a", 32'(want.low_a), 32'(got.low_a));
					compare_field("high_b", 32'(want.high_b), 32'(got.high_b));
					compare_field("low_b", 32'(want.low_b), 32'(got.low_b));
					compare_field("position", want.position, got.position);
					compare_field("at_target", 32'(want.at_target), 32'(got.at_target));
					compare_field("home_low_seen", 32'(want.home_low), 32'(got.home_low));
					compare_field("home_high_seen", 32'(want.home_high), 32'(got.home_high));
					compare_field("is_indexed", 32'(want.indexed), 32'(got.indexed));
					compare_field("homing_active", 32'(want.homing), 32'(got.homing));
					compare_field("stop_sequence", 32'(want.stop), 32'(got.stop));
					compare_field("pad", 32'(want.pad), 32'(got.pad));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				c.act = action_t'(s_axis_tuser);
				c.idx = s_axis_tdata[0];
				c.rot = s_axis_tdata[16:1];
				expected_status.push_back(apply_command(c));
			end
		end
	end

	// sender: bursts of items with random gaps between them
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || item_taken)) begin
			if (gap_left != 0) begin
				s_axis_tvalid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_cmds.size() != 0) begin
				next_cmd = pending_cmds.pop_front();
				s_axis_tuser <= next_cmd.act;
				s_axis_tdata <= {7'd0, next_cmd.rot, next_cmd.idx};
				s_axis_tvalid <= 1'b1;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: stall style is picked at random and changed when its hold count runs out
	always @(negedge clk) begin
		if (ready_hold == 0) begin
			ready_mode = stall_mode_t'($urandom_range(0, 3));
			ready_bits = $urandom | 32'h1;
			ready_hold = $urandom_range(16, 96);
		end else begin
			ready_hold = ready_hold - 1;
		end
		case (ready_mode)
			RDY_ALWAYS: m_axis_tready <= 1'b1;
			RDY_PATTERN: m_axis_tready <= ready_bits[ready_hold % 32];
			RDY_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
			default: m_axis_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic add_item(action_t act, logic idx, logic [15:0] rot);
		motor_cmd_t c;
		c.act = act;
		c.idx = idx;
		c.rot = rot;
		pending_cmds.push_back(c);
		n_queued++;
		if (act != ACT_NONE)
			n_moving++;
	endtask

	task automatic drain();
		while (n_checked != n_queued)
			@(negedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_limits(logic [15:0] spt, logic [15:0] lo, logic [15:0] hi);
		write_reg(REG_STEPS_PER_TURN, spt);
		write_reg(REG_ROTATION_MIN, lo);
		write_reg(REG_ROTATION_MAX, hi);
	endtask

	// mostly move/home sequences with random content, some raw noise
	task automatic run_random(int count);
		int start;
		int kind;
		int n;
		start = n_moving;
		while (n_moving - start < count) begin
			kind = $urandom_range(0, 9);
			if (kind < 5) begin
				add_item(ACT_SET_TARGET, 1'($urandom_range(0, 1)),
					16'($urandom_range(0, 24) - 12));
				n = $urandom_range(1, 40);
				repeat (n)
					add_item(ACT_TICK, $urandom_range(0, 15) == 0, 16'($urandom));
			end else if (kind < 7) begin
				add_item(ACT_HOME, 1'($urandom_range(0, 1)), 16'($urandom));
				n = $urandom_range(0, 12);
				repeat (n)
					add_item(ACT_TICK, 1'b0, 16'($urandom));
				n = $urandom_range(1, 3);
				repeat (n)
					add_item(ACT_TICK, 1'b1, 16'($urandom));
				n = $urandom_range(0, 6);
				repeat (n)
					add_item(ACT_TICK, 1'b0, 16'($urandom));
			end else if (kind == 7) begin
				// hold the index high across several ticks
				add_item(ACT_SET_TARGET, 1'b1, 16'($urandom_range(0, 24) - 12));
				n = $urandom_range(2, 8);
				repeat (n)
					add_item(ACT_TICK, 1'b1, 16'($urandom));
				n = $urandom_range(1, 8);
				repeat (n)
					add_item(ACT_TICK, 1'($urandom_range(0, 1)), 16'($urandom));
			end else begin
				n = $urandom_range(1, 4);
				repeat (n)
					add_item(action_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
						16'($urandom));
			end
		end
		drain();
	endtask

	initial begin
		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part under the reset limits
		add_item(ACT_NONE, 1'b1, 16'h5555);
		add_item(ACT_TICK, 1'b0, 16'hAAAA);
		add_item(ACT_SET_TARGET, 1'b0, 16'h7FFF);
		repeat (4)
			add_item(ACT_TICK, 1'b0, 16'h0000);
		add_item(ACT_TICK, 1'b1, 16'hFFFF);
		add_item(ACT_TICK, 1'b1, 16'h0000);
		add_item(ACT_SET_TARGET, 1'b1, 16'd50);
		add_item(ACT_TICK, 1'b0, 16'h0000);
		add_item(ACT_TICK, 1'b0, 16'h0000);
		add_item(ACT_SET_TARGET, 1'b0, 16'h8000);
		repeat (2)
			add_item(ACT_TICK, 1'b0, 16'h0000);
		add_item(ACT_HOME, 1'b0, 16'h0000);
		add_item(ACT_TICK, 1'b1, 16'h0000);
		add_item(ACT_HOME, 1'b1, 16'hFFFF);
		add_item(ACT_TICK, 1'b1, 16'h0000);
		add_item(ACT_SET_TARGET, 1'b0, 16'hFFFF);
		add_item(ACT_TICK, 1'b1, 16'h0000);
		add_item(ACT_TICK, 1'b1, 16'h0000);
		add_item(ACT_TICK, 1'b0, 16'h0000);
		add_item(ACT_SET_TARGET, 1'b1, 16'h0000);
		add_item(ACT_NONE, 1'b0, 16'hFFFF);
		drain();

		set_limits(16'd1, -16'sd8, 16'sd8);
		write_reg(REG_UNUSED, 16'hFFFF);
		run_random(180);
		set_limits(16'd65535, 16'h8000, 16'h7FFF);
		run_random(90);
		// min above max: everything lands on the max
		set_limits(16'd3, 16'sd6, -16'sd6);
		run_random(130);
		set_limits(16'd4, 16'd0, 16'h7FFF);
		run_random(130);
		set_limits(16'($urandom_range(1, 5)), 16'(-$urandom_range(1, 10)),
			16'($urandom_range(1, 10)));
		run_random(180);
		set_limits(16'd1, 16'h7FFF, 16'h8000);
		run_random(130);

		repeat (10)
			@(posedge clk);
		if (fail_count == 0 && expected_status.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/stpseq_pkg.sv
design/stpseq_target.sv
design/stpseq_tick.sv
design/stepper_full_step_sequencer_homing.sv
tb/testbench.sv
